// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: phase and status codes, the
// request and decode structs, character constants and the hex digit decoder.
// No dependencies.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;

  // UTF-8 framing
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [15:0] CODE_LIM1 = 16'h0080;
  localparam logic [15:0] CODE_LIM2 = 16'h0800;

  localparam logic [1:0] RES_MAX = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } req_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] accum;
    logic [1:0]  cnt;
    status_e     status;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
  } dec_t;

  // Return {valid, nibble} for an ASCII hex digit of either case
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- rtl/jsu_in_if.sv -----
// Request channel of the JSON string unescaper: one text byte per request.
// No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- rtl/jsu_out_if.sv -----
// Result channel of the JSON string unescaper: one decoded byte or status
// per transfer. No dependencies.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- rtl/jsu_decode.sv -----
// Combinational decode of one text byte against the current phase: next
// phase, next hex accumulator and up to three result bytes. Uses jsu_pkg.
module jsu_decode (
  input  jsu_pkg::req_t     req_i,
  input  jsu_pkg::phase_e   phase_i,
  input  logic [15:0]       accum_i,
  output jsu_pkg::dec_t     dec_o
);
  import jsu_pkg::*;

  logic [4:0]  hx;
  logic [15:0] code;
  logic [7:0]  c;

  assign c    = req_i.in_byte;
  assign hx   = hex_decode(c);
  assign code = {accum_i[11:0], hx[3:0]};

  // Decode one byte
  always_comb begin
    dec_o.phase  = phase_i;
    dec_o.accum  = accum_i;
    dec_o.cnt    = 2'd0;
    dec_o.status = ST_BYTE;
    dec_o.b0     = c;
    dec_o.b1     = 8'd0;
    dec_o.b2     = 8'd0;
    if (req_i.end_of_text) begin
      dec_o.phase  = PH_IDLE;
      dec_o.cnt    = 2'd1;
      dec_o.status = ST_BAD;
      dec_o.b0     = 8'd0;
    end else begin
      unique case (phase_i)
        PH_STR: begin
          if (c == CH_QUOTE) begin
            dec_o.phase  = PH_IDLE;
            dec_o.cnt    = 2'd1;
            dec_o.status = ST_DONE;
            dec_o.b0     = 8'd0;
          end else if (c == CH_BSLASH) begin
            dec_o.phase = PH_ESC;
          end else begin
            dec_o.cnt = 2'd1;
          end
        end
        PH_ESC: begin
          dec_o.phase = PH_STR;
          dec_o.cnt   = 2'd1;
          case (c)
            CH_N: dec_o.b0 = CTL_LF;
            CH_R: dec_o.b0 = CTL_CR;
            CH_T: dec_o.b0 = CTL_TAB;
            CH_B: dec_o.b0 = CTL_BS;
            CH_F: dec_o.b0 = CTL_FF;
            CH_U: begin
              dec_o.phase = PH_HEX1;
              dec_o.accum = 16'd0;
              dec_o.cnt   = 2'd0;
            end
            default: dec_o.b0 = c;
          endcase
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
          if (!hx[4]) begin
            dec_o.phase  = PH_IDLE;
            dec_o.cnt    = 2'd1;
            dec_o.status = ST_BAD;
            dec_o.b0     = 8'd0;
          end else begin
            dec_o.accum = code;
            case (phase_i)
              PH_HEX1: dec_o.phase = PH_HEX2;
              PH_HEX2: dec_o.phase = PH_HEX3;
              PH_HEX3: dec_o.phase = PH_HEX4;
              default: begin
                // Fourth digit: emit the code point as UTF-8
                dec_o.phase = PH_STR;
                if (code < CODE_LIM1) begin
                  dec_o.cnt = 2'd1;
                  dec_o.b0  = code[7:0];
                end else if (code < CODE_LIM2) begin
                  dec_o.cnt = 2'd2;
                  dec_o.b0  = UTF8_LEAD2 | {3'd0, code[10:6]};
                  dec_o.b1  = UTF8_CONT | {2'd0, code[5:0]};
                end else begin
                  dec_o.cnt = RES_MAX;
                  dec_o.b0  = UTF8_LEAD3 | {4'd0, code[15:12]};
                  dec_o.b1  = UTF8_CONT | {2'd0, code[11:6]};
                  dec_o.b2  = UTF8_CONT | {2'd0, code[5:0]};
                end
              end
            endcase
          end
        end
        default: begin
          // Idle: only an opening quote is legal
          if (c == CH_QUOTE) begin
            dec_o.phase = PH_STR;
          end else begin
            dec_o.phase  = PH_IDLE;
            dec_o.cnt    = 2'd1;
            dec_o.status = ST_BAD;
            dec_o.b0     = 8'd0;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/json_string_unescape_top.sv -----
// Top level of the JSON string unescaper: input register, decode and a
// three-entry result buffer. Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_decode.
//
//   channel  dir  payload                     meaning
//   req_i    in   in_byte[8], end_of_text     one text byte or end-of-text mark
//   rsp_o    out  out_byte[8], status[2], last decoded byte or string status
//
// One request a cycle enters the input register when ready; it is decoded in the
// next cycle and loads the result buffer once there is room. Requests with one or
// no result sustain one per cycle; a stalled result consumer backs up through the
// buffer. The fourth hex digit of a \u escape loads up to three results, which drain
// one per cycle; a later request with results waits in the input register until the
// last drains. Reset returns the decoder to idle and empties both registers.
module json_string_unescape_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    req_i,
  jsu_out_if.source rsp_o
);
  import jsu_pkg::*;

  phase_e      phase_q;
  logic [15:0] accum_q;
  logic        v1_q;
  req_t        item_q;
  logic [1:0]  cnt_q;
  status_e     status_q;
  logic [7:0]  byte_q [3];
  dec_t        dec;
  logic        pop;
  logic        load_ok;
  logic        adv1;
  logic        load;

  jsu_decode u_decode (
    .req_i   (item_q),
    .phase_i (phase_q),
    .accum_i (accum_q),
    .dec_o   (dec)
  );

  // Handshake control
  assign pop     = rsp_o.valid && rsp_o.ready;
  assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);
  assign adv1    = v1_q && ((dec.cnt == 2'd0) || load_ok);
  assign load    = adv1 && (dec.cnt != 2'd0);
  assign req_i.ready = !v1_q || adv1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (req_i.ready) begin
      v1_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q <= '{in_byte: req_i.in_byte, end_of_text: req_i.end_of_text};
    end
  end

  // Decoder state: advance when the held request retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      accum_q <= 16'd0;
    end else if (adv1) begin
      phase_q <= dec.phase;
      accum_q <= dec.accum;
    end
  end

  // Result buffer count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load) begin
      cnt_q <= dec.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result buffer payload: load all, shift on drain
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q[0] <= dec.b0;
      byte_q[1] <= dec.b1;
      byte_q[2] <= dec.b2;
      status_q  <= dec.status;
    end else if (pop) begin
      byte_q[0] <= byte_q[1];
      byte_q[1] <= byte_q[2];
    end
  end

  assign rsp_o.valid    = (cnt_q != 2'd0);
  assign rsp_o.out_byte = byte_q[0];
  assign rsp_o.status   = status_q;
  assign rsp_o.last     = (cnt_q == 2'd1);

`ifndef SYNTHESIS
  // Results load only into an empty or draining buffer
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("result buffer overwritten");

  // Status results are always single and last
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && status_q != ST_BYTE |-> cnt_q == 2'd1)
    else $error("status result not alone");

  // Draining the last result with nothing new empties the buffer
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cnt_q == 2'd1 && !load |=> !rsp_o.valid)
    else $error("buffer not empty after last drain");

  // A held request with results blocks input while the buffer is busy
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && dec.cnt != 2'd0 && cnt_q > 2'd1 |-> !req_i.ready)
    else $error("input accepted while result buffer is busy");

  // A multi-byte sequence comes only from the fourth hex digit
  a_multi_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && dec.cnt > 2'd1 |-> phase_q == PH_HEX4 && dec.phase == PH_STR)
    else $error("multi-byte result outside a unicode escape");
`endif

endmodule

// ----- tb/tb_json_string_unescape_top.sv -----
`timescale 1ns / 100ps
// Testbench for json_string_unescape_top: a queue-fed request driver, a result
// monitor and a built-in decoder model that predicts every result.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and the top level.
module tb_json_string_unescape_top;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } decoded_t;

  logic clk_i;
  logic rst_ni;
  int unsigned cyc;
  int unsigned err_cnt;

  text_item_t text_q[$];
  decoded_t   decoded_q[$];
  text_item_t drv_item;
  decoded_t   got_res;
  decoded_t   exp_res;

  // Decoder model state
  phase_e      dec_phase;
  logic [15:0] code_acc;

  jsu_in_if  req_if ();
  jsu_out_if rsp_if ();

  json_string_unescape_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // Random stall of about 6 percent, none inside a quiet window
  function automatic bit take_gap();
    if (cyc >= 200 && cyc < 350) begin
      return 1'b0;
    end
    return $urandom_range(99) < 6;
  endfunction

  function automatic int hex_value_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic expect_out(logic [7:0] b, status_e st, logic fin);
    decoded_t d;
    d.out_byte = b;
    d.status   = st;
    d.last     = fin;
    decoded_q.push_back(d);
  endtask

  // Advance the decoder model by one request and queue its results
  task automatic unescape_byte(logic [7:0] c, logic eot);
    int          h;
    logic [15:0] code;
    if (eot) begin
      dec_phase = PH_IDLE;
      expect_out(8'h00, ST_BAD, 1'b1);
    end else begin
      case (dec_phase)
        PH_IDLE: begin
          if (c == CH_QUOTE) begin
            dec_phase = PH_STR;
          end else begin
            expect_out(8'h00, ST_BAD, 1'b1);
          end
        end
        PH_STR: begin
          if (c == CH_QUOTE) begin
            dec_phase = PH_IDLE;
            expect_out(8'h00, ST_DONE, 1'b1);
          end else if (c == CH_BSLASH) begin
            dec_phase = PH_ESC;
          end else begin
            expect_out(c, ST_BYTE, 1'b1);
          end
        end
        PH_ESC: begin
          if (c == CH_U) begin
            code_acc  = 16'h0000;
            dec_phase = PH_HEX1;
          end else begin
            dec_phase = PH_STR;
            case (c)
              CH_N:    expect_out(CTL_LF, ST_BYTE, 1'b1);
              CH_R:    expect_out(CTL_CR, ST_BYTE, 1'b1);
              CH_T:    expect_out(CTL_TAB, ST_BYTE, 1'b1);
              CH_B:    expect_out(CTL_BS, ST_BYTE, 1'b1);
              CH_F:    expect_out(CTL_FF, ST_BYTE, 1'b1);
              default: expect_out(c, ST_BYTE, 1'b1);
            endcase
          end
        end
        default: begin
          h = hex_value_of(c);
          if (h < 0) begin
            dec_phase = PH_IDLE;
            expect_out(8'h00, ST_BAD, 1'b1);
          end else begin
            code_acc = {code_acc[11:0], 4'(h)};
            if (dec_phase != PH_HEX4) begin
              dec_phase = phase_e'(dec_phase + 3'd1);
            end else begin
              dec_phase = PH_STR;
              code = code_acc;
              if (code < CODE_LIM1) begin
                expect_out(code[7:0], ST_BYTE, 1'b1);
              end else if (code < CODE_LIM2) begin
                expect_out(UTF8_LEAD2 | {3'b000, code[10:6]}, ST_BYTE, 1'b0);
                expect_out(UTF8_CONT | {2'b00, code[5:0]}, ST_BYTE, 1'b1);
              end else begin
                expect_out(UTF8_LEAD3 | {4'h0, code[15:12]}, ST_BYTE, 1'b0);
                expect_out(UTF8_CONT | {2'b00, code[11:6]}, ST_BYTE, 1'b0);
                expect_out(UTF8_CONT | {2'b00, code[5:0]}, ST_BYTE, 1'b1);
              end
            end
          end
        end
      endcase
    end
  endtask

  // Request driver: hold a request until taken, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.in_byte     <= 8'h00;
      req_if.end_of_text <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        unescape_byte(req_if.in_byte, req_if.end_of_text);
      end
      if (!req_if.valid || req_if.ready) begin
        if (text_q.size() != 0 && !take_gap()) begin
          drv_item = text_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.in_byte     <= drv_item.in_byte;
          req_if.end_of_text <= drv_item.end_of_text;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got_res.out_byte = rsp_if.out_byte;
        got_res.status   = rsp_if.status;
        got_res.last     = rsp_if.last;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with none pending", int'(got_res), 0);
        end else begin
          exp_res = decoded_q.pop_front();
          if (got_res.out_byte !== exp_res.out_byte) begin
            report_mismatch("out_byte", got_res.out_byte, exp_res.out_byte);
          end
          if (got_res.status !== exp_res.status) begin
            report_mismatch("status", got_res.status, exp_res.status);
          end
          if (got_res.last !== exp_res.last) begin
            report_mismatch("last", got_res.last, exp_res.last);
          end
        end
      end
      rsp_if.ready <= !take_gap();
    end
  end

  task automatic add_byte(logic [7:0] b);
    text_item_t t;
    t.in_byte     = b;
    t.end_of_text = 1'b0;
    text_q.push_back(t);
  endtask

  // End-of-text mark; the byte field carries random junk
  task automatic add_eot();
    text_item_t t;
    t.in_byte     = 8'($urandom_range(255));
    t.end_of_text = 1'b1;
    text_q.push_back(t);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  task automatic add_hex_escape(logic [15:0] code);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) begin
      add_byte(hex_char(code[i*4 +: 4], bit'($urandom_range(1))));
    end
  endtask

  function automatic logic [7:0] pick_escape();
    logic [7:0] b;
    case ($urandom_range(8))
      0: b = CH_N;
      1: b = CH_R;
      2: b = CH_T;
      3: b = CH_B;
      4: b = CH_F;
      5: b = CH_QUOTE;
      6: b = CH_BSLASH;
      7: b = 8'h2F;
      default: begin
        do b = 8'($urandom_range(255)); while (b == CH_U);
      end
    endcase
    return b;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hFFFF, 16'h0800));
      default: return 16'($urandom_range(16'hDFFF, 16'hD800));
    endcase
  endfunction

  // Stimulus, reset and end of run
  initial begin
    int         pieces;
    int         k;
    int         n_ok;
    bit         aborted;
    logic [7:0] b;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cyc                = 0;
    err_cnt            = 0;
    dec_phase          = PH_IDLE;
    code_acc           = 16'h0000;
    req_if.valid       = 1'b0;
    req_if.in_byte     = 8'h00;
    req_if.end_of_text = 1'b0;
    rsp_if.ready       = 1'b0;

    // Directed: malformed while idle, byte extremes, escapes, code extremes,
    // clean close and a bad hex digit
    add_byte(8'h41);
    add_eot();
    add_byte(CH_QUOTE);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_BSLASH);
    add_byte(CH_N);
    add_hex_escape(16'hFFFF);
    add_hex_escape(16'h0000);
    add_byte(CH_QUOTE);
    add_byte(CH_QUOTE);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    add_byte(8'h67);

    // Random: mostly well-formed strings, some idle noise and broken strings;
    // stop once 172 or more requests are queued in all
    while (text_q.size() < 172) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) begin
          add_eot();
        end else begin
          do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
          add_byte(b);
        end
      end else begin
        add_byte(CH_QUOTE);
        pieces  = $urandom_range(8);
        aborted = 1'b0;
        for (int p = 0; p < pieces && !aborted; p++) begin
          k = $urandom_range(99);
          if (k < 40) begin
            do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
            add_byte(b);
          end else if (k < 65) begin
            add_byte(CH_BSLASH);
            add_byte(pick_escape());
          end else if (k < 93) begin
            add_hex_escape(pick_code());
          end else begin
            // Break the string inside a hex run, with a bad digit or an end of text
            aborted = 1'b1;
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            n_ok = $urandom_range(3);
            for (int i = 0; i < n_ok; i++) begin
              add_byte(hex_char(4'($urandom_range(15)), bit'($urandom_range(1))));
            end
            if ($urandom_range(3) == 0) begin
              add_eot();
            end else begin
              do b = 8'($urandom_range(255)); while (hex_value_of(b) >= 0);
              add_byte(b);
            end
          end
        end
        if (!aborted) begin
          if ($urandom_range(9) == 0) begin
            add_eot();
          end else begin
            add_byte(CH_QUOTE);
          end
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain stimulus, then outstanding results, then let the pipeline settle;
    // sample at the falling edge so the driver and monitor have settled
    while (text_q.size() != 0 || req_if.valid) @(negedge clk_i);
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_decode.sv
rtl/json_string_unescape_top.sv
tb/tb_json_string_unescape_top.sv
